/* hdl/pca_pkg.sv */
// Shared constants and types of the polygon centroid accumulator.
// No dependencies; used by pca_div and polygon_centroid_accumulator_unit.
package pca_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_WIDTH  = 16;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int IN_W     = 16;  // input coordinate width
  localparam int REL_W    = 17;  // coordinate relative to the first vertex
  localparam int PAIR_W   = 18;  // sum of two relative coordinates
  localparam int CROSS_W  = 34;  // one cross product term
  localparam int AREA_W   = 35;  // one edge's partial area
  localparam int PROD_W   = PAIR_W + AREA_W;
  localparam int ASUM_W   = 46;
  localparam int MSUM_W   = 64;
  localparam int DIVR_W   = ASUM_W + 2;  // three times the area sum
  localparam int DIVD_W   = MSUM_W;
  localparam int DSTEP_W  = $clog2(DIVD_W);

  localparam logic signed [MSUM_W-1:0] CLIP_HI =
    MSUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [MSUM_W-1:0] CLIP_LO = -CLIP_HI - MSUM_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_XY,
    ST_MUL_YX,
    ST_AREA,
    ST_MOM_X,
    ST_MOM_Y,
    ST_ACC,
    ST_DIV_SETUP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SUM,
    ST_CLIP,
    ST_EMIT
  } pca_state_e;

endpackage

/* hdl/pca_div.sv */
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on pca_pkg for operand widths.
module pca_div import pca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  logic               busy_q, done_q;
  logic [DSTEP_W-1:0] step_q;
  logic [DIVR_W-1:0]  rem_q, rem_d;
  logic [DIVD_W-1:0]  quo_q;
  logic [DIVR_W-1:0]  dvs_q;
  logic [DIVR_W:0]    rem_sh, trial;
  logic               bit_ok;

  // Remainder always stays below the divisor, so one extra bit covers the shift.
  assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};
  assign bit_ok = ~trial[DIVR_W];
  assign rem_d  = bit_ok ? trial[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + DSTEP_W'(1);
        if (step_q == DSTEP_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIVD_W-2:0], bit_ok};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/polygon_centroid_accumulator_unit.sv */
// Polygon centroid accumulator, top level (shoelace sums, fixed point).
// Depends on pca_pkg and pca_div.
//
// Vertices of one closed ring arrive one word at a time on s_axis, tlast on
// the final vertex. Each vertex after the first is taken relative to the
// first vertex and its edge from the previous vertex is accumulated with one
// shared 18x35 multiplier: two cross products, then the two moment products.
// A vertex is accepted and then takes six sequencer steps; the first
// vertex of a ring and any vertex beyond 1024 are only accepted and are not
// accumulated. After the last vertex each moment is divided by three times
// the area sum in a bit-serial divider, one axis after the other, the first
// vertex is added back and the result is clipped to 16 bits; the divider is
// skipped, and the first vertex is taken as it is, if the area is
// zero. s_axis_tready is high only while the sequencer is idle. The result
// sits in an output register, so the next ring may start while it waits;
// only the next result waits for it to be taken. A zero area reports the
// first vertex with the degenerate flag set.
module polygon_centroid_accumulator_unit import pca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] vertex_x, [31:16] vertex_y
  input  logic        s_axis_tlast,   // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] centroid_x, [31:16] centroid_y
  output logic [2:0]  m_axis_tuser    // [0] degenerate, [1] overflow, [2] saturated
);

  pca_state_e state_q, state_d;

  // control state
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q, last_q, axis_q, degen_q, sat_q, neg_q;
  logic             out_valid_q;

  // datapath
  logic signed [IN_W-1:0]   first_x_q, first_y_q;
  logic signed [REL_W-1:0]  prev_x_q, prev_y_q, rel_x_q, rel_y_q;
  logic signed [CROSS_W-1:0] t_q;
  logic signed [AREA_W-1:0] a_q, a_d;
  logic signed [ASUM_W-1:0] area_q;
  logic signed [MSUM_W-1:0] mom_x_q, mom_y_q, quo_q, sum_q;
  logic signed [DIVR_W-1:0] div_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PAIR_W-1:0] mul_a;
  logic signed [AREA_W-1:0] mul_b;
  logic signed [IN_W-1:0]   cx_q, cy_q, clip_v;
  logic                     clip_sat;

  logic signed [IN_W-1:0]   vx, vy, first_sel;
  logic signed [MSUM_W-1:0] mom_sel, mom_mag;
  logic [DIVR_W-1:0]        div_mag;
  logic                     accept, emit_ok, div_start, div_done;
  logic [DIVD_W-1:0]        div_quo;

  assign vx = s_axis_tdata[15:0];
  assign vy = s_axis_tdata[31:16];

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign emit_ok = ~out_valid_q | m_axis_tready;

  // ---- shared multiplier, operands picked by sequencer step ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_XY: begin
        mul_a = {prev_x_q[REL_W-1], prev_x_q};
        mul_b = AREA_W'(rel_y_q);
      end
      ST_MUL_YX: begin
        mul_a = {rel_x_q[REL_W-1], rel_x_q};
        mul_b = AREA_W'(prev_y_q);
      end
      ST_MOM_X: begin
        mul_a = {prev_x_q[REL_W-1], prev_x_q} + {rel_x_q[REL_W-1], rel_x_q};
        mul_b = a_q;
      end
      ST_MOM_Y: begin
        mul_a = {prev_y_q[REL_W-1], prev_y_q} + {rel_y_q[REL_W-1], rel_y_q};
        mul_b = a_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // partial area of the edge: x0*y1 - x1*y0
  assign a_d = {t_q[CROSS_W-1], t_q} - {prod_q[CROSS_W-1], prod_q[CROSS_W-1:0]};

  // ---- division operands for the axis being finished ----
  assign first_sel = axis_q ? first_y_q : first_x_q;
  assign mom_sel   = axis_q ? mom_y_q : mom_x_q;
  assign mom_mag   = mom_sel[MSUM_W-1] ? -mom_sel : mom_sel;
  assign div_mag   = div_q[DIVR_W-1] ? DIVR_W'(-div_q) : DIVR_W'(div_q);

  pca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIVD_W'(mom_mag)),
    .divisor_i  (div_mag),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // clip to the signed coordinate range
  always_comb begin
    clip_sat = 1'b0;
    clip_v   = IN_W'(sum_q);
    if (sum_q > CLIP_HI) begin
      clip_sat = 1'b1;
      clip_v   = IN_W'(CLIP_HI);
    end else if (sum_q < CLIP_LO) begin
      clip_sat = 1'b1;
      clip_v   = IN_W'(CLIP_LO);
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (cnt_q == '0 || cnt_q >= CNT_W'(MAX_VERTICES)) begin
            state_d = s_axis_tlast ? ST_DIV_SETUP : ST_IDLE;
          end else begin
            state_d = ST_MUL_XY;
          end
        end
      end
      ST_MUL_XY:    state_d = ST_MUL_YX;
      ST_MUL_YX:    state_d = ST_AREA;
      ST_AREA:      state_d = ST_MOM_X;
      ST_MOM_X:     state_d = ST_MOM_Y;
      ST_MOM_Y:     state_d = ST_ACC;
      ST_ACC:       state_d = last_q ? ST_DIV_SETUP : ST_IDLE;
      ST_DIV_SETUP: state_d = ST_DIV_START;
      ST_DIV_START: begin
        if (degen_q) begin
          state_d = ST_CLIP;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT:  state_d = div_done ? ST_SUM : ST_DIV_WAIT;
      ST_SUM:       state_d = ST_CLIP;
      ST_CLIP:      state_d = axis_q ? ST_EMIT : ST_DIV_START;
      ST_EMIT:      state_d = emit_ok ? ST_IDLE : ST_EMIT;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      axis_q      <= 1'b0;
      degen_q     <= 1'b0;
      sat_q       <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new word replaces the old one as it is taken
      if (state_q == ST_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= s_axis_tlast;
            if (cnt_q == '0) begin
              cnt_q <= CNT_W'(1);
              ovf_q <= 1'b0;
            end else if (cnt_q >= CNT_W'(MAX_VERTICES)) begin
              ovf_q <= 1'b1;
            end
          end
        end
        ST_ACC: cnt_q <= cnt_q + CNT_W'(1);
        ST_DIV_SETUP: begin
          axis_q  <= 1'b0;
          sat_q   <= 1'b0;
          degen_q <= (area_q == '0);
        end
        ST_DIV_START: neg_q <= mom_sel[MSUM_W-1] ^ div_q[DIVR_W-1];
        ST_CLIP: begin
          sat_q  <= sat_q | clip_sat;
          axis_q <= 1'b1;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rel_x_q <= {vx[IN_W-1], vx} - {first_x_q[IN_W-1], first_x_q};
          rel_y_q <= {vy[IN_W-1], vy} - {first_y_q[IN_W-1], first_y_q};
          if (cnt_q == '0) begin
            first_x_q <= vx;
            first_y_q <= vy;
            prev_x_q  <= '0;
            prev_y_q  <= '0;
            area_q    <= '0;
            mom_x_q   <= '0;
            mom_y_q   <= '0;
          end
        end
      end
      ST_MUL_YX: t_q <= prod_q[CROSS_W-1:0];
      ST_AREA: begin
        a_q    <= a_d;
        area_q <= area_q + {{(ASUM_W-AREA_W){a_d[AREA_W-1]}}, a_d};
      end
      ST_MOM_Y: mom_x_q <= mom_x_q + {{(MSUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      ST_ACC: begin
        mom_y_q  <= mom_y_q + {{(MSUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
        prev_x_q <= rel_x_q;
        prev_y_q <= rel_y_q;
      end
      ST_DIV_SETUP: begin
        // three times the area sum
        div_q <= {area_q[ASUM_W-1], area_q[ASUM_W-1], area_q}
               + {area_q[ASUM_W-1], area_q, 1'b0};
      end
      ST_DIV_START: begin
        if (degen_q) begin
          sum_q <= {{(MSUM_W-IN_W){first_sel[IN_W-1]}}, first_sel};
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          quo_q <= neg_q ? -$signed(div_quo) : $signed(div_quo);
        end
      end
      ST_SUM: sum_q <= quo_q + {{(MSUM_W-IN_W){first_sel[IN_W-1]}}, first_sel};
      ST_CLIP: begin
        if (axis_q) begin
          cy_q <= clip_v;
        end else begin
          cx_q <= clip_v;
        end
      end
      default: ;
    endcase
  end

  // output word register, loaded when the previous word is gone
  logic [31:0] out_data_q;
  logic [2:0]  out_user_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && emit_ok) begin
      out_data_q <= {cy_q, cx_q};
      out_user_q <= {sat_q, ovf_q, degen_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
